// ===== src/top_k_tracker_chrono_top_defines.svh =====
// Assertion helpers used by the tracker back end (tkc_back).
`ifndef TOP_K_TRACKER_CHRONO_TOP_DEFINES_SVH
`define TOP_K_TRACKER_CHRONO_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define TKC_IMPLY(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define TKC_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// ===== src/tkc_pkg.sv =====
package tkc_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam logic [6:0] KEEP_RESET = 7'd64;

  typedef enum logic [0:0] {
    ACT_ADD    = 1'b0,
    ACT_REPORT = 1'b1
  } action_t;

  // One word as it travels from the front to the back.
  typedef struct packed {
    action_t            act;
    logic [31:0]        moment;
    logic signed [16:0] alt;
  } item_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SCAN_RD,
    B_SCAN_CMP,
    B_DECIDE,
    B_SHIFT_RD,
    B_SHIFT_WR,
    B_WRITE,
    B_REP_RD,
    B_REP_OUT,
    B_EMPTY
  } back_state_t;

endpackage

// ===== src/top_k_tracker_chrono_top.sv =====
// Streaming top-k tracker. A word is accepted when start is high and busy
// is low; action 0 adds a measurement (numbered by a wrapping 32-bit moment
// counter, altitude upper minus lower) and action 1 reports the kept list,
// oldest first, one result at a time on strobe with last_of_report on
// the final one, or a single is_empty result when nothing is held. Results
// cannot be stalled: each is valid for exactly the one cycle strobe is high.
// A two-word queue sits between the front and the back, so up to two words
// are taken while the back is working. In the back, an add that appends is
// written at once; an add to a full store scans the entry memory, read at
// one address per cycle, for the minimum, then shifts the entries after the
// evicted position down one place, a read and a write per entry, and writes
// the new entry last; an add below the minimum is dropped after the scan.
// keep_count is written through keep_count_we; the user must write it only
// while idle, as the block itself does not enforce this.
module top_k_tracker_chrono_top #(
  parameter int CAPACITY = tkc_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               keep_count_we,
  input  logic [6:0]         keep_count_wdata,
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic [15:0]        lower_reading,
  input  logic [15:0]        upper_reading,
  output logic               strobe,
  output logic [31:0]        entry_moment,
  output logic signed [16:0] entry_altitude,
  output logic               is_empty,
  output logic               last_of_report
);
  import tkc_pkg::*;

  // Queue head as the back sees it.
  logic  q_valid;
  item_t q_head;
  logic  q_pop;

  tkc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .action        (action),
    .lower_reading (lower_reading),
    .upper_reading (upper_reading),
    .busy          (busy),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop)
  );

  tkc_back #(.CAPACITY(CAPACITY)) u_back (
    .clk              (clk),
    .rst              (rst),
    .keep_count_we    (keep_count_we),
    .keep_count_wdata (keep_count_wdata),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .strobe           (strobe),
    .entry_moment     (entry_moment),
    .entry_altitude   (entry_altitude),
    .is_empty         (is_empty),
    .last_of_report   (last_of_report)
  );

endmodule

// ===== src/tkc_front.sv =====
module tkc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               action,
  input  logic [15:0]        lower_reading,
  input  logic [15:0]        upper_reading,
  output logic               busy,
  output logic               q_valid,
  output tkc_pkg::item_t     q_head,
  input  logic               q_pop
);
  import tkc_pkg::*;

  logic [31:0] moment_counter;
  item_t       q0;
  item_t       q1;
  logic [1:0]  cnt;
  item_t       w;
  logic        push;

  assign busy    = (cnt == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt != 2'd0);
  assign q_head  = q0;

  // Adds are numbered here, in acceptance order, so the count stays exact.
  always_comb begin
    w.act    = action_t'(action);
    w.moment = moment_counter + 32'd1;
    w.alt    = $signed({1'b0, upper_reading}) - $signed({1'b0, lower_reading});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      moment_counter <= 32'd0;
      cnt            <= 2'd0;
    end else begin
      if (push && !action) begin
        moment_counter <= moment_counter + 32'd1;
      end
      unique case ({push, q_pop})
        2'b10: begin
          if (cnt == 2'd0) q0 <= w;
          else q1 <= w;
          cnt <= cnt + 2'd1;
        end
        2'b01: begin
          q0  <= q1;
          cnt <= cnt - 2'd1;
        end
        2'b11: begin
          if (cnt == 2'd1) begin
            q0 <= w;
          end else begin
            q0 <= q1;
            q1 <= w;
          end
        end
        2'b00: begin
        end
      endcase
    end
  end

endmodule

// ===== src/tkc_back.sv =====
`include "top_k_tracker_chrono_top_defines.svh"

module tkc_back #(
  parameter int CAPACITY = tkc_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               keep_count_we,
  input  logic [6:0]         keep_count_wdata,
  input  logic               q_valid,
  input  tkc_pkg::item_t     q_head,
  output logic               q_pop,
  output logic               strobe,
  output logic [31:0]        entry_moment,
  output logic signed [16:0] entry_altitude,
  output logic               is_empty,
  output logic               last_of_report
);
  import tkc_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [31:0]        mom_mem [CAPACITY];
  logic signed [16:0] alt_mem [CAPACITY];

  back_state_t        state;
  back_state_t        state_next;
  logic [6:0]         keep_count;
  logic [CW-1:0]      held;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      min_idx;
  logic signed [16:0] min_alt;
  item_t              cur;
  logic [31:0]        rd_mom;
  logic signed [16:0] rd_alt;

  logic [CW-1:0]      limit;
  logic               at_last;
  logic               mem_we;
  logic [AW-1:0]      raddr;
  logic [31:0]        wd_mom;
  logic signed [16:0] wd_alt;

  always_comb begin
    if (32'(keep_count) > 32'(CAPACITY)) limit = CW'(CAPACITY);
    else limit = CW'(keep_count);
  end

  assign at_last = (CW'(idx) == held - CW'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          if (q_head.act == ACT_REPORT) begin
            state_next = (held == CW'(0)) ? B_EMPTY : B_REP_RD;
          end else if (limit == CW'(0)) begin
            state_next = B_IDLE;
          end else if (held < limit) begin
            state_next = B_WRITE;
          end else begin
            state_next = B_SCAN_RD;
          end
        end
      end
      B_SCAN_RD:  state_next = B_SCAN_CMP;
      B_SCAN_CMP: state_next = at_last ? B_DECIDE : B_SCAN_RD;
      B_DECIDE: begin
        if (cur.alt < min_alt) state_next = B_IDLE;
        else if (CW'(min_idx) == held - CW'(1)) state_next = B_WRITE;
        else state_next = B_SHIFT_RD;
      end
      B_SHIFT_RD: state_next = B_SHIFT_WR;
      B_SHIFT_WR: state_next = (CW'(idx) + CW'(1) == held - CW'(1)) ? B_WRITE : B_SHIFT_RD;
      B_WRITE:    state_next = B_IDLE;
      B_REP_RD:   state_next = B_REP_OUT;
      B_REP_OUT:  state_next = at_last ? B_IDLE : B_REP_RD;
      B_EMPTY:    state_next = B_IDLE;
      default:    state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    raddr          = idx;
    wd_mom         = cur.moment;
    wd_alt         = cur.alt;
    strobe         = 1'b0;
    entry_moment   = rd_mom;
    entry_altitude = rd_alt;
    is_empty       = 1'b0;
    last_of_report = 1'b0;
    unique case (state)
      B_IDLE:     q_pop = q_valid;
      B_SHIFT_RD: raddr = AW'(CW'(idx) + CW'(1));
      B_SHIFT_WR: begin
        mem_we = 1'b1;
        wd_mom = rd_mom;
        wd_alt = rd_alt;
      end
      B_WRITE:    mem_we = 1'b1;
      B_REP_OUT: begin
        strobe         = 1'b1;
        last_of_report = at_last;
      end
      B_EMPTY: begin
        strobe         = 1'b1;
        entry_moment   = 32'd0;
        entry_altitude = 17'sd0;
        is_empty       = 1'b1;
        last_of_report = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mom_mem[idx] <= wd_mom;
      alt_mem[idx] <= wd_alt;
    end
    rd_mom <= mom_mem[raddr];
    rd_alt <= alt_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      keep_count <= KEEP_RESET;
      held       <= CW'(0);
    end else begin
      state <= state_next;
      if (keep_count_we) keep_count <= keep_count_wdata;
      unique case (state)
        B_IDLE: begin
          cur <= q_head;
          if (q_valid && q_head.act == ACT_ADD && limit != CW'(0) && held < limit) begin
            idx  <= AW'(held);
            held <= held + CW'(1);
          end else begin
            idx <= AW'(0);
          end
        end
        B_SCAN_CMP: begin
          if (idx == AW'(0) || rd_alt < min_alt) begin
            min_alt <= rd_alt;
            min_idx <= idx;
          end
          if (!at_last) idx <= idx + AW'(1);
        end
        B_DECIDE: begin
          if (CW'(min_idx) == held - CW'(1)) idx <= AW'(held - CW'(1));
          else idx <= min_idx;
        end
        B_SHIFT_WR: idx <= idx + AW'(1);
        B_REP_OUT:  if (!at_last) idx <= idx + AW'(1);
        default: begin
        end
      endcase
    end
  end

  `TKC_IMPLY(a_held_cap, 1'b1, held <= CW'(CAPACITY), "held count above capacity")
  `TKC_IMPLY(a_empty_held, strobe && is_empty, held == CW'(0), "empty word with entries held")
  `TKC_NEXT(a_last_idle, strobe && last_of_report, state == B_IDLE, "report did not end")

endmodule
